// ===== hw/rtl/vrrq_pkg.sv =====
// vrrq_pkg: shared sizes, codes and transaction types of the variable record ring queue
// no dependencies; imported by the queue top level, its checker and the test bench

package vrrq_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int HEADER_BYTES = 4;

  // derived widths
  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int POS_W  = ADDR_W + 1;
  localparam int LEN_W  = 16;
  localparam int SUM_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 2;
  localparam int CNT_W  = $clog2(BUFFER_BYTES / HEADER_BYTES) + 1;

  // fixed widths of the reported counters
  localparam int USED_OUT_W = 13;
  localparam int CNT_OUT_W  = 11;

  typedef enum logic [2:0] {
    OP_INS_HDR  = 3'd0,
    OP_INS_BYTE = 3'd1,
    OP_POP_HDR  = 3'd2,
    OP_POP_BYTE = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SKIP  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]       operation;
    logic [LEN_W-1:0] identifier;
    logic [LEN_W-1:0] length;
    logic [7:0]       data_in;
    logic [LEN_W-1:0] reader_capacity;
  } vrrq_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [LEN_W-1:0]      tag_out;
    logic [LEN_W-1:0]      length_out;
    logic [7:0]            data_out;
    logic                  last;
    logic [USED_OUT_W-1:0] bytes_used;
    logic [CNT_OUT_W-1:0]  record_count;
  } vrrq_out_t;

endpackage

// ===== hw/rtl/vrrq_ram.sv =====
// vrrq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module vrrq_ram #(
  parameter int DataWidth = 8,
  parameter int Depth     = 4096
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(Depth)-1:0]     waddr_i,
  input  logic [DataWidth-1:0]         wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(Depth)-1:0]     raddr_i,
  output logic [DataWidth-1:0]         rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/variable_record_ring_queue.sv =====
// variable_record_ring_queue: byte ring of tagged variable-length records
// depends on vrrq_pkg and vrrq_ram
//
//   channel   direction  payload      handshake
//   in        sink       vrrq_in_t    in_valid_i / in_ready_o
//   out       source     vrrq_out_t   out_valid_o / out_ready_i
//
// one transaction in flight; each input transaction yields exactly one output transaction
// payload bytes, clear and rejected ops pass from the execute state straight to the final state;
// an accepted insert header first writes its four header bytes one per cycle into the byte ram,
// a pop header reads its four header bytes via the registered read port, then evaluates them
// the input is taken again in the cycle after the result is loaded into the output register
// a stalled output holds the finished result and the next one waits in the final state
// reset clears pointers and counts at once; the byte ram is not cleared

module variable_record_ring_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vrrq_pkg::vrrq_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vrrq_pkg::vrrq_out_t out_data_o
);

  import vrrq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_HDR_WR   = 6'b000100,
    S_HDR_RD   = 6'b001000,
    S_HDR_EVAL = 6'b010000,
    S_FINISH   = 6'b100000
  } state_e;

  localparam logic [2:0] HdrLastIdx = 3'(HEADER_BYTES - 1);
  localparam logic [2:0] HdrDoneIdx = 3'(HEADER_BYTES);

  state_e state_q, state_d;
  vrrq_in_t item_q, item_d;

  // ring pointers and counters
  logic [POS_W-1:0] wp_q, wp_d;
  logic [POS_W-1:0] end_q, end_d;
  logic [POS_W-1:0] rp_q, rp_d;
  logic [POS_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] recs_q, recs_d;
  logic [LEN_W-1:0] wrem_q, wrem_d;
  logic             wrej_q, wrej_d;
  logic [LEN_W-1:0] rrem_q, rrem_d;
  logic [POS_W-1:0] pend_q, pend_d;

  // open record being written: its length and the next byte position
  logic [LEN_W-1:0] wlen_q, wlen_d;
  logic [POS_W-1:0] wcur_q, wcur_d;

  // header sequencing
  logic [2:0]  idx_q, idx_d;
  logic [31:0] hdr_q, hdr_d;

  // result being built
  status_e          res_status_q, res_status_d;
  logic [LEN_W-1:0] res_tag_q, res_tag_d;
  logic [LEN_W-1:0] res_len_q, res_len_d;
  logic             res_last_q, res_last_d;
  logic             res_from_ram_q, res_from_ram_d;

  logic      out_valid_q, out_valid_d;
  vrrq_out_t out_q, out_d;

  // byte ram access
  logic             ram_we, ram_we_g, ram_re;
  logic [POS_W-1:0] ram_wpos, ram_rpos;
  logic [7:0]       ram_wdata, ram_rdata, rd_byte;
  logic             rd_oob_q;

  // insert header fit check
  logic [SUM_W-1:0] copy, wp_copy;
  logic             no_room, at_end, over, can_wrap, clash, need_wrap, fits, wrap;

  // commit and release of record space
  logic             com_go, rel_go;
  logic [SUM_W-1:0] com_size, rel_size;
  logic [POS_W-1:0] com_wp;

  // header fields once all four bytes are in
  logic [LEN_W-1:0] rlen;
  logic [SUM_W-1:0] rsize;

  vrrq_ram #(
    .DataWidth(8),
    .Depth    (BUFFER_BYTES)
  ) u_vrrq_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we_g),
    .waddr_i(ram_wpos[ADDR_W-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_rpos[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // positions past the ring end are never stored and read as zero
  assign ram_we_g = ram_we && (ram_wpos < POS_W'(BUFFER_BYTES));
  assign rd_byte  = rd_oob_q ? 8'h00 : ram_rdata;

  // space check for insert header, evaluated on the held item
  assign copy      = SUM_W'(HEADER_BYTES) + SUM_W'(item_q.length);
  assign wp_copy   = SUM_W'(wp_q) + copy;
  assign no_room   = (SUM_W'(used_q) + copy) > SUM_W'(BUFFER_BYTES);
  assign at_end    = (wp_q == end_q);
  assign over      = wp_copy > SUM_W'(BUFFER_BYTES);
  assign can_wrap  = SUM_W'(rp_q) >= copy;
  assign clash     = (wp_q < end_q) && (wp_copy > SUM_W'(rp_q));
  assign need_wrap = !no_room && at_end && over;
  assign fits      = !no_room && (need_wrap ? can_wrap : !clash);
  assign wrap      = need_wrap && can_wrap;

  // committing the open record moves the write start past it
  assign com_size = SUM_W'(HEADER_BYTES) + SUM_W'(wlen_q);
  assign com_wp   = POS_W'(SUM_W'(wp_q) + com_size);

  assign rlen  = hdr_q[31:16];
  assign rsize = SUM_W'(HEADER_BYTES) + SUM_W'(rlen);

  always_comb begin
    state_d        = state_q;
    item_d         = item_q;
    wp_d           = wp_q;
    end_d          = end_q;
    rp_d           = rp_q;
    used_d         = used_q;
    recs_d         = recs_q;
    wrem_d         = wrem_q;
    wrej_d         = wrej_q;
    rrem_d         = rrem_q;
    pend_d         = pend_q;
    wlen_d         = wlen_q;
    wcur_d         = wcur_q;
    idx_d          = idx_q;
    hdr_d          = hdr_q;
    res_status_d   = res_status_q;
    res_tag_d      = res_tag_q;
    res_len_d      = res_len_q;
    res_last_d     = res_last_q;
    res_from_ram_d = res_from_ram_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q;
    ram_we         = 1'b0;
    ram_wpos       = wp_q;
    ram_wdata      = 8'h00;
    ram_re         = 1'b0;
    ram_rpos       = rp_q;
    com_go         = 1'b0;
    rel_go         = 1'b0;
    rel_size       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d   = ST_OK;
        res_tag_d      = '0;
        res_len_d      = '0;
        res_last_d     = 1'b0;
        res_from_ram_d = 1'b0;
        state_d        = S_FINISH;
        case (item_q.operation)
          OP_INS_HDR: begin
            if (wrem_q != '0 && !wrej_q) begin
              // accepted record still open
              res_status_d = ST_FULL;
            end else begin
              // a header ends any swallowing of a rejected record
              wrej_d = 1'b0;
              wrem_d = '0;
              if (!fits) begin
                res_status_d = ST_FULL;
                if (item_q.length != '0) begin
                  wrej_d = 1'b1;
                  wrem_d = item_q.length;
                end
              end else begin
                if (wrap) begin
                  wp_d = '0;
                end
                wcur_d  = (wrap ? '0 : wp_q) + POS_W'(HEADER_BYTES);
                wlen_d  = item_q.length;
                idx_d   = '0;
                state_d = S_HDR_WR;
              end
            end
          end

          OP_INS_BYTE: begin
            if (wrem_q == '0) begin
              res_status_d = ST_FULL;
            end else if (wrej_q) begin
              // swallow a byte of a rejected record
              res_status_d = ST_FULL;
              wrem_d       = wrem_q - LEN_W'(1);
              if (wrem_q == LEN_W'(1)) begin
                wrej_d = 1'b0;
              end
            end else begin
              ram_we    = 1'b1;
              ram_wpos  = wcur_q;
              ram_wdata = item_q.data_in;
              wcur_d    = wcur_q + POS_W'(1);
              wrem_d    = wrem_q - LEN_W'(1);
              if (wrem_q == LEN_W'(1)) begin
                com_go = 1'b1;
              end
            end
          end

          OP_POP_HDR: begin
            if (rrem_q != '0) begin
              res_status_d = ST_FULL;
            end else if (recs_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              // reader at the end mark wraps to the ring start
              if (rp_q == end_q) begin
                rp_d  = '0;
                end_d = wp_q;
              end
              idx_d   = '0;
              state_d = S_HDR_RD;
            end
          end

          OP_POP_BYTE: begin
            if (rrem_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              ram_re         = 1'b1;
              ram_rpos       = rp_q;
              res_from_ram_d = 1'b1;
              rp_d           = rp_q + POS_W'(1);
              rrem_d         = rrem_q - LEN_W'(1);
              if (rrem_q == LEN_W'(1)) begin
                res_last_d = 1'b1;
                rel_go     = 1'b1;
                rel_size   = SUM_W'(pend_q);
                pend_d     = '0;
              end
            end
          end

          OP_CLEAR: begin
            wp_d   = '0;
            end_d  = '0;
            rp_d   = '0;
            used_d = '0;
            recs_d = '0;
            wrem_d = '0;
            wrej_d = 1'b0;
            rrem_d = '0;
            pend_d = '0;
          end

          default: begin
            res_status_d = ST_FULL;
          end
        endcase
      end

      S_HDR_WR: begin
        // identifier low, identifier high, length low, length high
        ram_we   = 1'b1;
        ram_wpos = wp_q + POS_W'(idx_q);
        case (idx_q[1:0])
          2'd0:    ram_wdata = item_q.identifier[7:0];
          2'd1:    ram_wdata = item_q.identifier[15:8];
          2'd2:    ram_wdata = item_q.length[7:0];
          default: ram_wdata = item_q.length[15:8];
        endcase
        idx_d = idx_q + 3'd1;
        if (idx_q == HdrLastIdx) begin
          state_d = S_FINISH;
          if (wlen_q == '0) begin
            com_go = 1'b1;
          end else begin
            wrem_d = wlen_q;
          end
        end
      end

      S_HDR_RD: begin
        // reads issued on the first four steps, each byte landing via the registered read port
        if (idx_q != HdrDoneIdx) begin
          ram_re   = 1'b1;
          ram_rpos = rp_q + POS_W'(idx_q);
        end
        if (idx_q != '0) begin
          hdr_d = {rd_byte, hdr_q[31:8]};
        end
        idx_d = idx_q + 3'd1;
        if (idx_q == HdrDoneIdx) begin
          state_d = S_HDR_EVAL;
        end
      end

      S_HDR_EVAL: begin
        res_tag_d = hdr_q[15:0];
        state_d   = S_FINISH;
        if (item_q.reader_capacity < rlen) begin
          // reader too small: drop the whole record now
          res_status_d = ST_SKIP;
          rp_d         = rp_q + POS_W'(rsize);
          rel_go       = 1'b1;
          rel_size     = rsize;
        end else begin
          res_len_d = rlen;
          rp_d      = rp_q + POS_W'(HEADER_BYTES);
          if (rlen == '0) begin
            rel_go   = 1'b1;
            rel_size = rsize;
          end else begin
            rrem_d = rlen;
            pend_d = POS_W'(rsize);
          end
        end
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status       = res_status_q;
          out_d.tag_out      = res_tag_q;
          out_d.length_out   = res_len_q;
          out_d.data_out     = res_from_ram_q ? rd_byte : 8'h00;
          out_d.last         = res_last_q;
          out_d.bytes_used   = USED_OUT_W'(used_q);
          out_d.record_count = CNT_OUT_W'(recs_q);
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // record becomes visible after its last byte, or after its header when it has no payload
    if (com_go) begin
      used_d = POS_W'(SUM_W'(used_q) + com_size);
      recs_d = recs_q + CNT_W'(1);
      wp_d   = com_wp;
      end_d  = (com_wp > end_q) ? com_wp : end_q;
    end

    // record space handed back, saturating at zero
    if (rel_go) begin
      used_d = (SUM_W'(used_q) >= rel_size) ? POS_W'(SUM_W'(used_q) - rel_size) : '0;
      if (recs_q != '0) begin
        recs_d = recs_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      end_q       <= '0;
      rp_q        <= '0;
      used_q      <= '0;
      recs_q      <= '0;
      wrem_q      <= '0;
      wrej_q      <= 1'b0;
      rrem_q      <= '0;
      pend_q      <= '0;
      rd_oob_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wp_q        <= wp_d;
      end_q       <= end_d;
      rp_q        <= rp_d;
      used_q      <= used_d;
      recs_q      <= recs_d;
      wrem_q      <= wrem_d;
      wrej_q      <= wrej_d;
      rrem_q      <= rrem_d;
      pend_q      <= pend_d;
      if (ram_re) begin
        rd_oob_q <= ram_rpos >= POS_W'(BUFFER_BYTES);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q         <= item_d;
    wlen_q         <= wlen_d;
    wcur_q         <= wcur_d;
    idx_q          <= idx_d;
    hdr_q          <= hdr_d;
    res_status_q   <= res_status_d;
    res_tag_q      <= res_tag_d;
    res_len_q      <= res_len_d;
    res_last_q     <= res_last_d;
    res_from_ram_q <= res_from_ram_d;
    out_q          <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/vrrq_checker.sv =====
// vrrq_checker: port-level assertions for the variable record ring queue, bound to the top level
// depends on vrrq_pkg

module vrrq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input vrrq_pkg::vrrq_in_t  in_data_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input vrrq_pkg::vrrq_out_t out_data_i
);

  import vrrq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output transaction changed while stalled");

  // one transaction at a time: no input right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken in back-to-back cycles");

  // no records means no bytes held, and the other way round
  a_count_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_data_i.record_count == '0) == (out_data_i.bytes_used == '0)))
    else $error("record count and byte usage disagree");

  // final payload byte carries an ok status and no header fields
  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.last |->
      out_data_i.status == ST_OK && out_data_i.tag_out == '0 && out_data_i.length_out == '0)
    else $error("last flag on a non-payload result");

endmodule

bind variable_record_ring_queue vrrq_checker u_vrrq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);

// ===== tb/variable_record_ring_queue_test.sv =====
// variable_record_ring_queue_test: self-checking bench for the variable record ring queue
// depends on vrrq_pkg and the variable_record_ring_queue rtl; predicts every result
// from a cycle-free model of the ring and compares each output transaction field by field

module variable_record_ring_queue_test;
  import vrrq_pkg::*;

  // highest code the 3-bit operation field can carry; codes above clear are unused
  localparam int TOP_OP_CODE = 7;
  // bytes a random header may ask for so that it can never fit
  localparam int NEVER_FITS = BUFFER_BYTES - HEADER_BYTES + 1;

  typedef struct {
    vrrq_in_t item;
    bit       drain;  // hold this transaction back until every result is in
  } stim_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  vrrq_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  vrrq_out_t out_data_o;

  stim_t     pending_items[$];
  vrrq_out_t predicted_replies[$];
  int        sent_cnt = 0;      // input transactions accepted
  int        reply_cnt = 0;     // output transactions accepted
  int        mismatches = 0;
  bit        gen_done = 1'b0;
  bit        idle_mode = 1'b1;
  logic [7:0] mode_timer = '0;
  int        send_hold = 0;
  int        recv_hold = 0;

  // ring model state
  bit [7:0]    ring_mem [BUFFER_BYTES];
  int unsigned wr_base, ring_end, rd_ptr, used_cnt, rec_cnt;
  int unsigned wr_left, rd_left, free_on_done;
  bit          wr_drop;

  variable_record_ring_queue DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // ring model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] mem_byte(int unsigned pos);
    return (pos < BUFFER_BYTES) ? ring_mem[pos] : 8'h00;
  endfunction

  function automatic void put_byte(int unsigned pos, logic [7:0] v);
    if (pos < BUFFER_BYTES) ring_mem[pos] = v;
  endfunction

  // payload length kept in the header that starts at pos
  function automatic int unsigned header_len(int unsigned pos);
    return 32'({mem_byte(pos + 3), mem_byte(pos + 2)});
  endfunction

  function automatic void give_back(int unsigned size);
    used_cnt = (used_cnt >= size) ? used_cnt - size : 0;
    if (rec_cnt > 0) rec_cnt--;
  endfunction

  // record complete: it becomes visible and the write base moves past it
  function automatic void seal_record();
    int unsigned size;
    size = HEADER_BYTES + header_len(wr_base);
    used_cnt += size;
    rec_cnt++;
    wr_base += size;
    if (wr_base > ring_end) ring_end = wr_base;
  endfunction

  function automatic void ring_reset();
    wr_base = 0;
    ring_end = 0;
    rd_ptr = 0;
    used_cnt = 0;
    rec_cnt = 0;
    wr_left = 0;
    wr_drop = 1'b0;
    rd_left = 0;
    free_on_done = 0;
  endfunction

  // one accepted transaction in, the reply it must produce out
  function automatic vrrq_out_t advance_ring(vrrq_in_t t);
    vrrq_out_t   r;
    int unsigned span, slen, cursor;
    bit          fits;
    r = '0;
    r.status = ST_OK;
    case (t.operation)
      OP_INS_HDR: begin
        if (wr_left != 0 && !wr_drop) begin
          // accepted record still open: header ignored
          r.status = ST_FULL;
        end else begin
          span = HEADER_BYTES + t.length;
          fits = 1'b1;
          wr_drop = 1'b0;
          wr_left = 0;
          if (used_cnt + span > BUFFER_BYTES) begin
            fits = 1'b0;
          end else if (wr_base == ring_end && wr_base + span > BUFFER_BYTES) begin
            // no room before the end: wrap to zero if the freed head area is big enough
            if (rd_ptr >= span) wr_base = 0;
            else fits = 1'b0;
          end else if (wr_base < ring_end && wr_base + span > rd_ptr) begin
            fits = 1'b0;
          end
          if (!fits) begin
            r.status = ST_FULL;
            if (t.length != 0) begin
              wr_drop = 1'b1;
              wr_left = 32'(t.length);
            end
          end else begin
            put_byte(wr_base, t.identifier[7:0]);
            put_byte(wr_base + 1, t.identifier[15:8]);
            put_byte(wr_base + 2, t.length[7:0]);
            put_byte(wr_base + 3, t.length[15:8]);
            if (t.length == 0) seal_record();
            else wr_left = 32'(t.length);
          end
        end
      end
      OP_INS_BYTE: begin
        if (wr_left == 0) begin
          r.status = ST_FULL;
        end else if (wr_drop) begin
          // payload of a rejected record is swallowed
          r.status = ST_FULL;
          wr_left--;
          if (wr_left == 0) wr_drop = 1'b0;
        end else begin
          slen = header_len(wr_base);
          cursor = wr_base + HEADER_BYTES + slen - wr_left;
          put_byte(cursor, t.data_in);
          wr_left--;
          if (wr_left == 0) seal_record();
        end
      end
      OP_POP_HDR: begin
        if (rd_left != 0) begin
          r.status = ST_FULL;
        end else if (rec_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (rd_ptr == ring_end) begin
            rd_ptr = 0;
            ring_end = wr_base;
          end
          r.tag_out = {mem_byte(rd_ptr + 1), mem_byte(rd_ptr)};
          slen = header_len(rd_ptr);
          span = HEADER_BYTES + slen;
          if (t.reader_capacity < slen) begin
            // reader too small: whole record dropped at once
            r.status = ST_SKIP;
            rd_ptr += span;
            give_back(span);
          end else begin
            r.length_out = slen[15:0];
            if (slen == 0) begin
              rd_ptr += span;
              give_back(span);
            end else begin
              rd_ptr += HEADER_BYTES;
              rd_left = slen;
              free_on_done = span;
            end
          end
        end
      end
      OP_POP_BYTE: begin
        if (rd_left == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = mem_byte(rd_ptr);
          rd_ptr++;
          rd_left--;
          if (rd_left == 0) begin
            r.last = 1'b1;
            give_back(free_on_done);
            free_on_done = 0;
          end
        end
      end
      OP_CLEAR: ring_reset();
      default: r.status = ST_FULL;
    endcase
    r.bytes_used = used_cnt[USED_OUT_W-1:0];
    r.record_count = rec_cnt[CNT_OUT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building; a negative argument means a random value
  // ---------------------------------------------------------------------------

  task automatic queue_op(logic [2:0] op, int len = -1, int cap = -1, int id = -1,
                          int din = -1, bit drain = 1'b0);
    stim_t s;
    s.item.operation       = op;
    s.item.identifier      = (id < 0) ? 16'($urandom) : 16'(id);
    s.item.length          = (len < 0) ? 16'($urandom) : 16'(len);
    s.item.data_in         = (din < 0) ? 8'($urandom) : 8'(din);
    s.item.reader_capacity = (cap < 0) ? 16'($urandom) : 16'(cap);
    s.drain                = drain;
    pending_items.push_back(s);
  endtask

  task automatic write_record(int len);
    queue_op(OP_INS_HDR, len);
    repeat (len) queue_op(OP_INS_BYTE);
  endtask

  // payload bytes are only asked for when the reader is large enough
  task automatic read_record(int len, int cap);
    queue_op(OP_POP_HDR, -1, cap);
    if (cap >= len) repeat (len) queue_op(OP_POP_BYTE);
  endtask

  // last stretch of the run goes without idling on either side
  function automatic bit in_tail();
    return gen_done && pending_items.size() < 40;
  endfunction

  task automatic field_check(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents pending transactions, predicts at acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : driver
    bit taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      taken = in_valid_i && in_ready_o;
      if (taken) begin
        predicted_replies.push_back(advance_ring(in_data_i));
        sent_cnt <= sent_cnt + 1;
      end
      // valid stays up with the same payload until the transaction is taken
      if (!in_valid_i || taken) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() == 0 ||
                     (pending_items[0].drain && sent_cnt + taken != reply_cnt)) begin
          in_valid_i <= 1'b0;
        end else if (idle_mode && !in_tail() && $urandom_range(0, 3) == 0) begin
          // idle burst: valid stays low now and while send_hold counts down
          send_hold = $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else begin
          in_data_i <= pending_items[0].item;
          pending_items.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every output transaction, drives back-pressure
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    vrrq_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        reply_cnt <= reply_cnt + 1;
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %p", $time, out_data_o);
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          field_check("status", 16'(want.status), 16'(out_data_o.status));
          field_check("tag_out", want.tag_out, out_data_o.tag_out);
          field_check("length_out", want.length_out, out_data_o.length_out);
          field_check("data_out", 16'(want.data_out), 16'(out_data_o.data_out));
          field_check("last", 16'(want.last), 16'(out_data_o.last));
          field_check("bytes_used", 16'(want.bytes_used), 16'(out_data_o.bytes_used));
          field_check("record_count", 16'(want.record_count),
                      16'(out_data_o.record_count));
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else if (idle_mode && !in_tail() && $urandom_range(0, 4) == 0) begin
        recv_hold = $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // idling switched on and off in stretches so some stretches run at full rate
  always @(posedge clk_i) begin
    mode_timer <= mode_timer + 1'b1;
    if (mode_timer == '0) idle_mode <= ($urandom_range(0, 3) != 0);
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int len, cap, k, pick, start_n;
    int gen_lens[$];  // lengths of records the stimulus believes are held

    ring_reset();

    // directed: empty pops, stray byte, unused codes
    queue_op(OP_POP_HDR, -1, 16'hFFFF);
    queue_op(OP_POP_BYTE);
    queue_op(OP_INS_BYTE, -1, -1, -1, 8'hFF);
    for (int u = OP_CLEAR + 1; u <= TOP_OP_CODE; u++) queue_op(3'(u));
    // zero-length record commits at its header
    queue_op(OP_INS_HDR, 0, -1, 16'hFFFF);
    // header arriving while a record is open is ignored
    queue_op(OP_INS_HDR, 2, -1, 0);
    queue_op(OP_INS_BYTE, -1, -1, -1, 8'h00);
    queue_op(OP_INS_HDR, 7);
    queue_op(OP_INS_BYTE, -1, -1, -1, 8'hFF);
    // oversize record rejected, payload swallowed until a new header
    queue_op(OP_INS_HDR, 16'hFFFF, 0);
    queue_op(OP_INS_BYTE);
    queue_op(OP_INS_BYTE);
    write_record(1);
    // zero-length pop, skip for capacity, header while bytes pending
    queue_op(OP_POP_HDR, -1, 0);
    queue_op(OP_POP_HDR, -1, 1);
    queue_op(OP_POP_HDR, -1, 16'hFFFF);
    queue_op(OP_POP_HDR, -1, 16'hFFFF);
    queue_op(OP_POP_BYTE);
    queue_op(OP_POP_BYTE);
    // clear drops an open record
    queue_op(OP_INS_HDR, 3);
    queue_op(OP_INS_BYTE);
    queue_op(OP_CLEAR);
    queue_op(OP_POP_HDR);
    queue_op(OP_INS_BYTE);

    // random: mostly whole records and whole reads, with noise and broken sequences
    queue_op(OP_POP_HDR, -1, -1, -1, -1, 1'b1);
    start_n = pending_items.size();
    while (pending_items.size() - start_n < 420) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        if (pick < 3) begin
          queue_op(OP_INS_HDR, $urandom_range(NEVER_FITS, 16'hFFFF));
          repeat ($urandom_range(0, 3)) queue_op(OP_INS_BYTE);
        end else if (pick < 7 && len > 1) begin
          k = $urandom_range(1, len - 1);
          queue_op(OP_INS_HDR, len);
          repeat (k) queue_op(OP_INS_BYTE);
          queue_op(OP_INS_HDR);
          repeat (len - k) queue_op(OP_INS_BYTE);
          gen_lens.push_back(len);
        end else begin
          write_record(len);
          gen_lens.push_back(len);
        end
      end else if (pick < 88) begin
        if (gen_lens.size() == 0) begin
          queue_op(OP_POP_HDR);
        end else begin
          len = gen_lens.pop_front();
          case ($urandom_range(0, 4))
            0: cap = len;
            1: cap = 16'hFFFF;
            2: cap = (len > 0) ? $urandom_range(0, len - 1) : 0;
            default: cap = $urandom_range(len, 16'hFFFF);
          endcase
          if (cap >= len && len > 0 && $urandom_range(0, 9) == 0) begin
            // second header in the middle of a read
            queue_op(OP_POP_HDR, -1, cap);
            queue_op(OP_POP_BYTE);
            queue_op(OP_POP_HDR);
            repeat (len - 1) queue_op(OP_POP_BYTE);
          end else begin
            read_record(len, cap);
          end
        end
      end else begin
        case ($urandom_range(0, 3))
          0: queue_op(OP_INS_BYTE);
          1: queue_op(OP_POP_BYTE);
          2: queue_op(3'($urandom_range(OP_CLEAR + 1, TOP_OP_CODE)));
          default: begin
            if ($urandom_range(0, 3) == 0) begin
              queue_op(OP_CLEAR);
              gen_lens.delete();
            end else begin
              queue_op(OP_POP_BYTE);
            end
          end
        endcase
      end
    end
    gen_done = 1'b1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything sent and every result back, then a margin for stray outputs
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || sent_cnt != reply_cnt);
    repeat (20) @(posedge clk_i);
    if (predicted_replies.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, predicted_replies.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
